@@ src/independent_watchdog_keyed_macros.svh @@
// Assertion helpers shared by the watchdog sources.
// Each macro samples on clk and is quiet while rst_n is low.
`ifndef INDEPENDENT_WATCHDOG_KEYED_MACROS_SVH
`define INDEPENDENT_WATCHDOG_KEYED_MACROS_SVH

`ifndef ASSERT_OFF

// Property that must hold at every clock edge out of reset.
`define IWK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a clock edge out of reset.
`define IWK_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`else

`define IWK_ASSERT(label, prop, msg)
`define IWK_NEVER(label, cond, msg)

`endif

`endif

@@ src/iwk_pkg.sv @@
package iwk_pkg;

    // Request types.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Register indexes.
    localparam logic [2:0] REG_KEY       = 3'd0;
    localparam logic [2:0] REG_PRESCALER = 3'd1;
    localparam logic [2:0] REG_RELOAD    = 3'd2;
    localparam logic [2:0] REG_STATUS    = 3'd3;
    localparam logic [2:0] REG_WINDOW    = 3'd4;

    // Key values.
    localparam logic [15:0] KEY_UNLOCK = 16'h5555;
    localparam logic [15:0] KEY_START  = 16'hCCCC;
    localparam logic [15:0] KEY_RELOAD = 16'hAAAA;

    // Largest prescaler code used by a reload.
    localparam logic [2:0] MAX_CODE = 3'd6;

    // Reset value of the reload and window registers.
    localparam logic [11:0] SETTING_RESET = 12'hFFF;

    // Largest value the down counter can hold (reload of 4095 plus one).
    localparam logic [12:0] DOWN_MAX = 13'd4096;

    // One result item.
    typedef struct packed {
        logic [11:0] read_data;
        logic        timeout;
        logic        reset_request;
    } iwk_result_t;

endpackage

@@ src/iwk_core.sv @@
`include "independent_watchdog_keyed_macros.svh"

module iwk_core
    import iwk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        accept,
    input  logic [1:0]  req_type,
    input  logic [2:0]  reg_index,
    input  logic [15:0] write_data,
    output iwk_result_t result
);

    logic        reset_enable_reg;
    logic        running_reg, running_next;
    logic        unlocked_reg, unlocked_next;
    logic        armed_reg, armed_next;
    logic [2:0]  prescale_setting_reg, prescale_setting_next;
    logic [11:0] reload_setting_reg, reload_setting_next;
    logic [11:0] window_setting_reg, window_setting_next;
    logic [2:0]  latched_divider_reg, latched_divider_next;
    logic [7:0]  prescale_count_reg, prescale_count_next;
    logic [12:0] down_count_reg, down_count_next;

    logic [2:0]  reload_code;
    logic [7:0]  divisor_low;
    logic [9:0]  divisor_full;
    logic [7:0]  count_inc;
    logic [12:0] down_dec;
    logic        do_reload;

    // Prescaler code latched at reload, clamped to the largest supported code.
    assign reload_code = (prescale_setting_reg > MAX_CODE) ? MAX_CODE : prescale_setting_reg;

    // Divisor of 4 << code; a divisor of 256 wraps to zero in the 8-bit count.
    assign divisor_full = 10'd4 << latched_divider_reg;
    assign divisor_low  = divisor_full[7:0];
    assign count_inc    = prescale_count_reg + 8'd1;
    assign down_dec     = (down_count_reg != 13'd0) ? (down_count_reg - 13'd1) : down_count_reg;

    // Next state and result for the request at the input.
    always_comb
    begin
        running_next          = running_reg;
        unlocked_next         = unlocked_reg;
        armed_next            = armed_reg;
        prescale_setting_next = prescale_setting_reg;
        reload_setting_next   = reload_setting_reg;
        window_setting_next   = window_setting_reg;
        latched_divider_next  = latched_divider_reg;
        prescale_count_next   = prescale_count_reg;
        down_count_next       = down_count_reg;
        do_reload             = 1'b0;
        result                = '0;

        case (req_type)
            REQ_TICK:
            begin
                if (armed_reg)
                begin
                    if (count_inc == divisor_low)
                    begin
                        prescale_count_next = 8'd0;
                        down_count_next     = down_dec;
                        if (down_dec == 13'd0)
                        begin
                            armed_next     = 1'b0;
                            result.timeout = 1'b1;
                        end
                    end
                    else
                    begin
                        prescale_count_next = count_inc;
                    end
                end
            end
            REQ_READ:
            begin
                case (reg_index)
                    REG_PRESCALER: result.read_data = {9'd0, prescale_setting_reg};
                    REG_RELOAD:    result.read_data = reload_setting_reg;
                    REG_WINDOW:    result.read_data = window_setting_reg;
                    default:       result.read_data = 12'd0;
                endcase
            end
            REQ_WRITE:
            begin
                if (reg_index == REG_KEY)
                begin
                    if (write_data == KEY_UNLOCK)
                    begin
                        unlocked_next = 1'b1;
                    end
                    else if (write_data == KEY_START)
                    begin
                        running_next = 1'b1;
                        do_reload    = 1'b1;
                    end
                    else if (write_data == KEY_RELOAD && running_reg)
                    begin
                        do_reload = 1'b1;
                    end
                end
                else if (unlocked_reg)
                begin
                    case (reg_index)
                        REG_PRESCALER: prescale_setting_next = write_data[2:0];
                        REG_RELOAD:    reload_setting_next   = write_data[11:0];
                        REG_WINDOW:    window_setting_next   = write_data[11:0];
                        default:       ;
                    endcase
                end
            end
            default: ;
        endcase

        // A reload restarts the prescaler and arms a fresh countdown.
        if (do_reload)
        begin
            latched_divider_next = reload_code;
            prescale_count_next  = 8'd0;
            down_count_next      = {1'b0, reload_setting_reg} + 13'd1;
            armed_next           = 1'b1;
        end

        result.reset_request = result.timeout & reset_enable_reg;
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_enable_reg     <= 1'b0;
            running_reg          <= 1'b0;
            unlocked_reg         <= 1'b0;
            armed_reg            <= 1'b0;
            prescale_setting_reg <= 3'd0;
            reload_setting_reg   <= SETTING_RESET;
            window_setting_reg   <= SETTING_RESET;
            latched_divider_reg  <= 3'd0;
            prescale_count_reg   <= 8'd0;
            down_count_reg       <= 13'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                reset_enable_reg <= cfg_wdata;
            end
            if (accept)
            begin
                running_reg          <= running_next;
                unlocked_reg         <= unlocked_next;
                armed_reg            <= armed_next;
                prescale_setting_reg <= prescale_setting_next;
                reload_setting_reg   <= reload_setting_next;
                window_setting_reg   <= window_setting_next;
                latched_divider_reg  <= latched_divider_next;
                prescale_count_reg   <= prescale_count_next;
                down_count_reg       <= down_count_next;
            end
        end
    end

    // A timeout leaves the watchdog disarmed until the next reload.
    `IWK_ASSERT(a_timeout_disarms, (accept && result.timeout) |=> !armed_reg, "timeout did not disarm")

    // A start key always runs and arms the countdown with a nonzero count.
    `IWK_ASSERT(a_start_arms, (accept && req_type == REQ_WRITE && reg_index == REG_KEY && write_data == KEY_START) |=> (armed_reg && running_reg && down_count_reg != 13'd0), "start key did not arm")

    // Once unlocked, the registers stay unlocked until reset.
    `IWK_ASSERT(a_unlock_sticky, unlocked_reg |=> unlocked_reg, "unlock was lost")

    // The countdown never exceeds the largest reload plus one.
    `IWK_NEVER(a_down_range, down_count_reg > DOWN_MAX, "down counter out of range")

endmodule

@@ src/iwk_out_buf.sv @@
`include "independent_watchdog_keyed_macros.svh"

module iwk_out_buf
    import iwk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  iwk_result_t push_data,
    output logic        space,
    output logic        out_valid,
    input  logic        out_ready,
    output iwk_result_t out_data
);

    logic        main_valid_reg, main_valid_next;
    logic        skid_valid_reg, skid_valid_next;
    iwk_result_t main_data_reg, main_data_next;
    iwk_result_t skid_data_reg, skid_data_next;
    logic        pop;

    // New requests are taken while the skid slot is free.
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_data_reg;
    assign pop       = main_valid_reg && out_ready;

    // Output slot refills from the skid slot first, then from a new result.
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_data_next  = main_data_reg;
        skid_data_next  = skid_data_reg;
        if (!main_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                main_valid_next = 1'b1;
                main_data_next  = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_valid_next = 1'b1;
                main_data_next  = push_data;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    // Valid flags.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        main_data_reg <= main_data_next;
        skid_data_reg <= skid_data_next;
    end

    // The skid slot only fills behind a waiting output.
    `IWK_ASSERT(a_skid_behind_main, skid_valid_reg |-> main_valid_reg, "skid holds data with empty output")

    // A held result plus a new one must never overflow the buffer.
    `IWK_NEVER(a_no_overflow, push && skid_valid_reg, "push into full buffer")

endmodule

@@ src/independent_watchdog_keyed.sv @@
// Keyed independent watchdog.
// Input channel (in_valid/in_ready) carries one request per item: a tick of
// the low-speed clock, a register read or a register write (req_type,
// reg_index, write_data). Output channel (out_valid/out_ready) returns one
// result per request: read_data, timeout and reset_request.
// The reset_enable bit is written through cfg_we/cfg_wdata; the user must write
// it only while idle, which the block itself does not enforce. Each request is
// handled by the combinational state update in iwk_core; its result is registered
// in the output buffer. One request per cycle is sustained as long as the
// receiver takes results.
// When the receiver stalls, a two-entry output buffer holds the waiting
// result and one more; in_ready drops only once both entries are full.
// Reset clears the watchdog: stopped, locked, disarmed, prescaler 0, reload
// and window 4095, reset_enable 0, output buffer empty.
module independent_watchdog_keyed
    import iwk_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [2:0]  reg_index,
    input  logic [15:0] write_data,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] read_data,
    output logic        timeout,
    output logic        reset_request
);

    logic        accept;
    iwk_result_t core_result;
    iwk_result_t out_data;

    // A request is taken when the output buffer has room.
    assign accept = in_valid && in_ready;

    // Watchdog state and per-request result.
    iwk_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .accept     (accept),
        .req_type   (req_type),
        .reg_index  (reg_index),
        .write_data (write_data),
        .result     (core_result)
    );

    // Result register with skid slot.
    iwk_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (core_result),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign read_data     = out_data.read_data;
    assign timeout       = out_data.timeout;
    assign reset_request = out_data.reset_request;

endmodule

@@ verif/independent_watchdog_keyed_tb.sv @@
`timescale 1ns / 100ps

module independent_watchdog_keyed_tb;
    import iwk_pkg::*;

    // Codes the package leaves unnamed.
    localparam logic [1:0] REQ_UNDEFINED = 2'd3;
    localparam logic [2:0] REG_SPARE = 3'd5;
    localparam logic [15:0] KEY_OTHER = 16'h1234;

    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 4;
    localparam int PHASE_REQS = 45;

    typedef struct packed {
        logic [1:0]  kind;
        logic [2:0]  idx;
        logic [15:0] data;
    } wd_request_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic        cfg_wdata = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  req_type = '0;
    logic [2:0]  reg_index = '0;
    logic [15:0] write_data = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [11:0] read_data;
    logic        timeout;
    logic        reset_request;

    independent_watchdog_keyed uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .req_type     (req_type),
        .reg_index    (reg_index),
        .write_data   (write_data),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .read_data    (read_data),
        .timeout      (timeout),
        .reset_request(reset_request)
    );

    // Requests waiting to be driven and results still owed by the block.
    wd_request_t pending_reqs[$];
    iwk_result_t expected_results[$];

    // Watchdog state as the testbench predicts it.
    logic        wd_running;
    logic        wd_unlocked;
    logic        wd_armed;
    logic [2:0]  presc_reg;
    logic [11:0] reload_reg;
    logic [11:0] window_reg;
    logic [2:0]  div_code;
    logic [7:0]  presc_cnt;
    logic [12:0] down_cnt;
    logic        rst_req_en;

    // Run controls and counters.
    bit no_gaps = 1'b0;
    bit long_hold_go = 1'b0;
    bit long_hold_done = 1'b0;
    int hold_left = 0;
    int queued_total = 0;
    int n_accepted = 0;
    int n_checked = 0;
    int n_timeouts = 0;
    int n_reset_reqs = 0;
    int n_input_stalls = 0;
    int errors = 0;
    int cycle_count = 0;
    wd_request_t next_req;
    iwk_result_t oldest;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Latch a fresh countdown from the current prescaler and reload settings.
    task automatic restart_countdown();
        div_code = (presc_reg > MAX_CODE) ? MAX_CODE : presc_reg;
        presc_cnt = '0;
        down_cnt = {1'b0, reload_reg} + 13'd1;
        wd_armed = 1'b1;
    endtask

    // Apply one accepted request to the predicted state and queue its result.
    task automatic advance_watchdog(input wd_request_t r);
        logic [8:0]  divisor;
        iwk_result_t res;
        res = '0;
        if (r.kind == REQ_TICK)
        begin
            if (wd_armed)
            begin
                divisor = 9'd4 << div_code;
                presc_cnt = presc_cnt + 8'd1;
                // A divisor of 256 wraps the count to zero, which still matches.
                if (presc_cnt == divisor[7:0])
                begin
                    presc_cnt = '0;
                    if (down_cnt != 0)
                        down_cnt = down_cnt - 13'd1;
                    if (down_cnt == 0)
                    begin
                        wd_armed = 1'b0;
                        res.timeout = 1'b1;
                        res.reset_request = rst_req_en;
                    end
                end
            end
        end
        else if (r.kind == REQ_READ)
        begin
            case (r.idx)
                REG_PRESCALER: res.read_data = {9'd0, presc_reg};
                REG_RELOAD:    res.read_data = reload_reg;
                REG_WINDOW:    res.read_data = window_reg;
                default:       res.read_data = '0;
            endcase
        end
        else if (r.kind == REQ_WRITE)
        begin
            if (r.idx == REG_KEY)
            begin
                if (r.data == KEY_UNLOCK)
                    wd_unlocked = 1'b1;
                else if (r.data == KEY_START)
                begin
                    wd_running = 1'b1;
                    restart_countdown();
                end
                else if (r.data == KEY_RELOAD && wd_running)
                    restart_countdown();
            end
            else if (wd_unlocked)
            begin
                case (r.idx)
                    REG_PRESCALER: presc_reg = r.data[2:0];
                    REG_RELOAD:    reload_reg = r.data[11:0];
                    REG_WINDOW:    window_reg = r.data[11:0];
                    default:       ;
                endcase
            end
        end
        expected_results.push_back(res);
    endtask

    task automatic queue_req(input logic [1:0] k, input logic [2:0] i, input logic [15:0] d);
        pending_reqs.push_back('{kind: k, idx: i, data: d});
        queued_total++;
    endtask

    // Program prescaler and reload, kick the watchdog, then feed it ticks
    // mixed with reads and the odd reload key.
    task automatic queue_countdown_seq(input logic [2:0] code, input logic [11:0] reload);
        logic [31:0] r32;
        int          needed;
        int          n_ticks;
        needed = (int'(reload) + 1) * (4 << ((code > MAX_CODE) ? MAX_CODE : code));
        if ($urandom_range(0, 99) < 20)
            queue_req(REQ_WRITE, REG_KEY, KEY_UNLOCK);
        r32 = $urandom;
        queue_req(REQ_WRITE, REG_PRESCALER, {r32[15:3], code});
        r32 = $urandom;
        queue_req(REQ_WRITE, REG_RELOAD, {r32[15:12], reload});
        if ($urandom_range(0, 99) < 20)
        begin
            r32 = $urandom;
            queue_req(REQ_WRITE, REG_WINDOW, r32[15:0]);
        end
        queue_req(REQ_WRITE, REG_KEY, ($urandom_range(0, 99) < 85) ? KEY_START : KEY_RELOAD);
        if ($urandom_range(0, 99) < 10)
            n_ticks = $urandom_range(1, needed);
        else
            n_ticks = needed + $urandom_range(0, 2);
        for (int t = 0; t < n_ticks; t++)
        begin
            if ($urandom_range(0, 99) < 10)
                queue_req(REQ_READ, 3'($urandom_range(0, 7)), 16'($urandom));
            if ($urandom_range(0, 99) < 3)
                queue_req(REQ_WRITE, REG_KEY, KEY_RELOAD);
            queue_req(REQ_TICK, 3'($urandom_range(0, 7)), 16'($urandom));
        end
    endtask

    // Mostly well-formed countdowns with random content, the rest raw noise.
    task automatic queue_random_phase(input int count);
        int          target;
        logic [2:0]  code;
        logic [11:0] reload;
        int          pick;
        target = queued_total + count;
        while (queued_total < target)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                begin
                    code = 3'($urandom_range(0, 1));
                    reload = 12'($urandom_range(0, 3));
                end
                else if (pick < 95)
                begin
                    code = 3'($urandom_range(2, 3));
                    reload = 12'($urandom_range(0, 1));
                end
                else
                begin
                    code = 3'($urandom_range(4, 7));
                    reload = '0;
                end
                queue_countdown_seq(code, reload);
            end
            else
            begin
                repeat ($urandom_range(1, 3))
                    queue_req(2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              16'($urandom));
            end
        end
    endtask

    // Wait until every request is taken and every result is back.
    task automatic wait_drained();
        @(negedge clk);
        while (pending_reqs.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reset_enable(input logic value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        rst_req_en = value;
        @(negedge clk);
    endtask

    // Request driver: holds each request until the block takes it.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= '0;
            reg_index <= '0;
            write_data <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                advance_watchdog('{kind: req_type, idx: reg_index, data: write_data});
                n_accepted++;
            end
            if (in_valid && !in_ready)
                n_input_stalls++;
            if (!in_valid || in_ready)
            begin
                if (pending_reqs.size() != 0 && (no_gaps || $urandom_range(0, 99) >= 34))
                begin
                    next_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= next_req.kind;
                    reg_index <= next_req.idx;
                    write_data <= next_req.data;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each result against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with no request waiting for it");
                    errors++;
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    n_checked++;
                    if (read_data !== oldest.read_data)
                    begin
                        $error("read_data: expected %0h, got %0h", oldest.read_data, read_data);
                        errors++;
                    end
                    if (timeout !== oldest.timeout)
                    begin
                        $error("timeout: expected %0b, got %0b", oldest.timeout, timeout);
                        errors++;
                    end
                    if (reset_request !== oldest.reset_request)
                    begin
                        $error("reset_request: expected %0b, got %0b",
                               oldest.reset_request, reset_request);
                        errors++;
                    end
                    if (oldest.timeout)
                        n_timeouts++;
                    if (oldest.reset_request)
                        n_reset_reqs++;
                end
            end
            // Ready for the next cycle: long hold first, then random stalls.
            if (hold_left != 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (long_hold_go && !long_hold_done)
            begin
                hold_left = LONG_HOLD_CYCLES;
                long_hold_done = 1'b1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= no_gaps || ($urandom_range(0, 99) >= 34);
        end
    end

    // Watchdog on the testbench itself.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        wd_running = 1'b0;
        wd_unlocked = 1'b0;
        wd_armed = 1'b0;
        presc_reg = '0;
        reload_reg = SETTING_RESET;
        window_reg = SETTING_RESET;
        div_code = '0;
        presc_cnt = '0;
        down_cnt = '0;
        rst_req_en = 1'b0;

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        write_reset_enable(1'b0);

        // Directed: reset values, locking, key handling, store widths and
        // the shortest countdown.
        queue_req(REQ_READ, REG_PRESCALER, 16'h0000);
        queue_req(REQ_READ, REG_RELOAD, 16'hFFFF);
        queue_req(REQ_READ, REG_WINDOW, 16'h0000);
        queue_req(REQ_READ, REG_KEY, 16'h0000);
        queue_req(REQ_READ, REG_STATUS, 16'h0000);
        queue_req(REQ_WRITE, REG_PRESCALER, 16'hFFFF);
        queue_req(REQ_READ, REG_PRESCALER, 16'h0000);
        queue_req(REQ_UNDEFINED, REG_SPARE, 16'hFFFF);
        queue_req(REQ_WRITE, REG_KEY, KEY_RELOAD);
        queue_req(REQ_WRITE, REG_KEY, KEY_OTHER);
        queue_req(REQ_WRITE, REG_KEY, KEY_UNLOCK);
        queue_req(REQ_WRITE, REG_PRESCALER, 16'hFFFF);
        queue_req(REQ_READ, REG_PRESCALER, 16'h0000);
        queue_req(REQ_WRITE, REG_RELOAD, 16'hFFFF);
        queue_req(REQ_READ, REG_RELOAD, 16'h0000);
        queue_req(REQ_WRITE, REG_WINDOW, 16'h0000);
        queue_req(REQ_READ, REG_WINDOW, 16'hFFFF);
        queue_req(REQ_WRITE, REG_STATUS, 16'hFFFF);
        queue_req(REQ_READ, REG_SPARE, 16'h0000);
        queue_req(REQ_WRITE, REG_RELOAD, 16'h0000);
        queue_req(REQ_WRITE, REG_PRESCALER, 16'h0000);
        queue_req(REQ_WRITE, REG_KEY, KEY_START);
        // Four ticks expire the countdown; the fifth finds it disarmed.
        repeat (5) queue_req(REQ_TICK, REG_KEY, 16'h0000);
        wait_drained();

        // Reset requests enabled, including the largest prescaler divisor.
        write_reset_enable(1'b1);
        queue_countdown_seq(3'd7, 12'd0);
        queue_random_phase(PHASE_REQS);
        wait_drained();

        // Reset requests disabled, both sides running without gaps.
        write_reset_enable(1'b0);
        no_gaps = 1'b1;
        queue_random_phase(PHASE_REQS);
        wait_drained();
        no_gaps = 1'b0;

        // Reset requests enabled again, with one long output stall.
        write_reset_enable(1'b1);
        queue_random_phase(PHASE_REQS);
        long_hold_go = 1'b1;
        wait_drained();

        $display("Checked %0d results for %0d requests: %0d timeouts, %0d reset requests.",
                 n_checked, n_accepted, n_timeouts, n_reset_reqs);
        $display("reset_enable toggled 0/1/0/1; input stalled by the block for %0d cycles.",
                 n_input_stalls);
        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
